>>> design/assert_macros.svh
// Assertion macros used by word_table_prefix_filter.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> design/wtpf_pkg.sv
package wtpf_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int MAX_PREFIX  = 8;
    localparam int LIST_LIMIT  = 32;
    localparam int LETTERS     = 26;

    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int LIST_W     = $clog2(LIST_LIMIT + 1);
    localparam int WORD_W     = 64;
    localparam int IDX_W      = 11;
    localparam int LEN_W      = 4;
    localparam int MAX_LIST_W = 6;
    localparam int COUNT_W    = 12;

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [COUNT_W-1:0] ZERO_LEN_COUNT =
        (TABLE_DEPTH > 4095) ? COUNT_SAT : COUNT_W'(TABLE_DEPTH);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  entry_index;
        logic [WORD_W-1:0] chars;
        logic [LEN_W-1:0]  char_count;
    } in_t;

    typedef struct packed {
        logic               is_list_item;
        logic [IDX_W-1:0]   word_index;
        logic [LETTERS-1:0] letter_mask;
        logic [COUNT_W-1:0] match_count;
        logic               exact_found;
        logic [IDX_W-1:0]   exact_index;
        logic               last;
    } out_t;

    typedef struct packed {
        logic               hit;
        logic               eq;
        logic [LETTERS-1:0] mask;
    } match_t;

endpackage

>>> design/wtpf_ram.sv
module wtpf_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/wtpf_match.sv
module wtpf_match
    import wtpf_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [WORD_W-1:0] prefix,
    input  logic [LEN_W-1:0]  len,
    output match_t            result
);

    always_comb
    begin
        logic       ok;
        logic       early;
        logic [7:0] wb;
        logic [7:0] pb;
        logic [7:0] nb;

        ok    = 1'b1;
        early = 1'b0;
        for (int i = 0; i < MAX_PREFIX; i++)
        begin
            wb = word[8*i +: 8];
            pb = prefix[8*i +: 8];
            if (ok && !early && (LEN_W'(i) < len))
            begin
                if (wb != pb)
                begin
                    ok = 1'b0;
                end
                else if (wb == 8'h00)
                begin
                    early = 1'b1;
                end
            end
        end

        // The byte after the prefix; a full-length prefix is followed by zero.
        nb = (len < LEN_W'(8)) ? word[8*len[2:0] +: 8] : 8'h00;

        result.hit = ok;
        if (early)
        begin
            result.eq   = 1'b1;
            result.mask = '1;
        end
        else
        begin
            result.eq   = (nb == 8'h00);
            result.mask = '0;
            if (nb >= CHAR_A && nb <= CHAR_Z)
            begin
                result.mask = LETTERS'(1) << (nb - CHAR_A);
            end
        end
    end

endmodule

>>> design/word_table_prefix_filter.sv
// Prefix search over a table of short words.
//
// Request channel (req_valid/req_ready/req): a beat with req_type load writes
// chars into table slot entry_index and returns nothing. A query beat starts a
// scan of the whole table; req_ready stays low until the summary beat is issued.
// Response channel (rsp_valid/rsp_ready/rsp): a query returns one list beat per
// matching word, in table order, up to max_list of them (at most LIST_LIMIT),
// then one summary beat with last set; an empty prefix gets only the summary.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes max_list; it is
// always ready and must only be written while no query is in flight.
// Throughput: a query scans the whole table through the single table read
// port, which reads one entry per cycle while the scan is not paused. The next
// request can be accepted as soon as the summary beat appears.
// Stalls: a response register sits between the scan and the receiver. When a
// list beat is waiting and the next match to be listed is found, the scan
// pauses with its read data held until the beat is taken, so no beat is lost.
// Reset clears the control state and sets max_list to 4. The table itself is
// not cleared: every entry must be loaded before the first query.
module word_table_prefix_filter
    import wtpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  in_t                   req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output out_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [MAX_LIST_W-1:0] cfg_data
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      rd_addr_reg, rd_addr_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]     pipe_addr_reg, pipe_addr_next;
    logic [WORD_W-1:0]     prefix_reg, prefix_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LIST_W-1:0]     limit_reg, limit_next;
    logic [LIST_W-1:0]     listed_reg, listed_next;
    logic [LETTERS-1:0]    mask_reg, mask_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  exact_reg, exact_next;
    logic [IDX_W-1:0]      exact_idx_reg, exact_idx_next;
    logic                  out_vld_reg, out_vld_next;
    out_t                  out_reg, out_next;
    logic [MAX_LIST_W-1:0] max_list_reg, max_list_next;

    logic              req_fire;
    logic              ram_we;
    logic              ram_re;
    logic [WORD_W-1:0] ram_rdata;
    match_t            hit_info;
    logic              out_free;
    logic              list_on;
    logic              need_out;
    logic              adv;

    wtpf_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(req.entry_index)),
        .wdata (req.chars),
        .re    (ram_re),
        .raddr (rd_addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    wtpf_match u_match (
        .word   (ram_rdata),
        .prefix (prefix_reg),
        .len    (len_reg),
        .result (hit_info)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    // Loads outside the table range are dropped.
    assign ram_we = req_fire && (req.req_type == REQ_LOAD) &&
                    (32'(req.entry_index) < TABLE_DEPTH);

    // The scan pauses only when the word in the read register must be listed
    // and the response register cannot take it this cycle.
    assign out_free = !out_vld_reg || rsp_ready;
    assign list_on  = (len_reg != '0) && (listed_reg < limit_reg);
    assign need_out = pipe_vld_reg && hit_info.hit && list_on;
    assign adv      = !(need_out && !out_free);
    assign ram_re   = (state_reg == ST_SCAN) && adv &&
                      (rd_addr_reg < CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        pipe_vld_next  = pipe_vld_reg;
        pipe_addr_next = pipe_addr_reg;
        prefix_next    = prefix_reg;
        len_next       = len_reg;
        limit_next     = limit_reg;
        listed_next    = listed_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        exact_next     = exact_reg;
        exact_idx_next = exact_idx_reg;
        out_vld_next   = out_vld_reg;
        out_next       = out_reg;
        max_list_next  = max_list_reg;

        if (cfg_valid && cfg_ready)
        begin
            max_list_next = cfg_data;
        end

        if (out_vld_reg && rsp_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == REQ_QUERY))
                begin
                    prefix_next    = req.chars;
                    len_next       = (req.char_count > LEN_W'(MAX_PREFIX)) ?
                                     LEN_W'(MAX_PREFIX) : req.char_count;
                    limit_next     = (max_list_reg > MAX_LIST_W'(LIST_LIMIT)) ?
                                     LIST_W'(LIST_LIMIT) : LIST_W'(max_list_reg);
                    listed_next    = '0;
                    mask_next      = '0;
                    count_next     = '0;
                    exact_next     = 1'b0;
                    exact_idx_next = '0;
                    rd_addr_next   = '0;
                    pipe_vld_next  = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (adv)
                begin
                    if (pipe_vld_reg && hit_info.hit)
                    begin
                        mask_next = mask_reg | hit_info.mask;
                        if (count_reg != COUNT_SAT)
                        begin
                            count_next = count_reg + COUNT_W'(1);
                        end
                        if (hit_info.eq && !exact_reg)
                        begin
                            exact_next     = 1'b1;
                            exact_idx_next = IDX_W'(pipe_addr_reg);
                        end
                    end
                    if (need_out)
                    begin
                        listed_next           = listed_reg + LIST_W'(1);
                        out_vld_next          = 1'b1;
                        out_next              = '0;
                        out_next.is_list_item = 1'b1;
                        out_next.word_index   = IDX_W'(pipe_addr_reg);
                    end
                    pipe_vld_next = ram_re;
                    if (ram_re)
                    begin
                        pipe_addr_next = rd_addr_reg[ADDR_W-1:0];
                        rd_addr_next   = rd_addr_reg + CNT_W'(1);
                    end
                end
                if (!pipe_vld_reg && (rd_addr_reg == CNT_W'(TABLE_DEPTH)))
                begin
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                if (out_free)
                begin
                    out_vld_next          = 1'b1;
                    out_next              = '0;
                    out_next.letter_mask  = mask_reg;
                    out_next.match_count  = (len_reg == '0) ? ZERO_LEN_COUNT : count_reg;
                    out_next.exact_found  = exact_reg;
                    out_next.exact_index  = exact_idx_reg;
                    out_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_addr_reg   <= '0;
            pipe_vld_reg  <= 1'b0;
            pipe_addr_reg <= '0;
            prefix_reg    <= '0;
            len_reg       <= '0;
            limit_reg     <= '0;
            listed_reg    <= '0;
            mask_reg      <= '0;
            count_reg     <= '0;
            exact_reg     <= 1'b0;
            exact_idx_reg <= '0;
            out_vld_reg   <= 1'b0;
            out_reg       <= '0;
            max_list_reg  <= MAX_LIST_W'(4);
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            pipe_vld_reg  <= pipe_vld_next;
            pipe_addr_reg <= pipe_addr_next;
            prefix_reg    <= prefix_next;
            len_reg       <= len_next;
            limit_reg     <= limit_next;
            listed_reg    <= listed_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            exact_reg     <= exact_next;
            exact_idx_reg <= exact_idx_next;
            out_vld_reg   <= out_vld_next;
            out_reg       <= out_next;
            max_list_reg  <= max_list_next;
        end
    end

    // A new request is never taken while table data is still in flight.
    `ASSERT_NEVER(a_ready_while_scan, clk, rst_n, req_ready && pipe_vld_reg, "request taken during scan")

    // The number of listed words never passes the per-query limit.
    `ASSERT_CLK(a_list_limit, clk, rst_n, (state_reg != ST_SCAN) || (listed_reg <= limit_reg), "list limit exceeded")

    // The summary beat always ends the query and frees the request channel.
    `ASSERT_CLK(a_sum_ends, clk, rst_n, (state_reg == ST_SUM && out_free) |=> (state_reg == ST_IDLE && out_vld_reg && out_reg.last), "summary not issued")

    // The read address never runs past the table.
    `ASSERT_NEVER(a_addr_range, clk, rst_n, rd_addr_reg > CNT_W'(TABLE_DEPTH), "read address out of range")

endmodule
